@@ rtl/core/lfds_pkg.sv @@
package lfds_pkg;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_ON      = 3'd1,
    MODE_FADEIN  = 3'd2,
    MODE_FADEOUT = 3'd3,
    MODE_DIMMED  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_SECOND = 2'd0,
    ACT_MINUTE = 2'd1,
    ACT_SWITCH = 2'd2,
    ACT_DIM    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CFG_TARGET   = 3'd0,
    CFG_LIMIT    = 3'd1,
    CFG_INTERVAL = 3'd2,
    CFG_STEP     = 3'd3,
    CFG_DIM_DUR  = 3'd4,
    CFG_ON_TIME  = 3'd5,
    CFG_OFF_TIME = 3'd6,
    CFG_FLAGS    = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] FADE_SEC_MAX = 16'hFFFF;
  localparam logic [16:0] DIM_SEC_MAX  = 17'h1FFFF;
  localparam logic [6:0]  PERCENT_MAX  = 7'd100;
  localparam logic [12:0] RECIP_100    = 13'd5243;

  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_AW    = 2;

  typedef struct packed {
    logic [6:0]  target;
    logic [15:0] interval;
    logic [6:0]  step;
    logic [16:0] dim_ticks;
    logic [10:0] on_time;
    logic [10:0] off_time;
    logic        fading;
    logic        sched;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic        switch_on;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic        req_on;
    logic [6:0]  level;
    mode_t       saved_mode;
    logic [6:0]  saved_level;
    logic [15:0] fade_sec;
    logic [16:0] dim_sec;
  } lstate_t;

  typedef struct packed {
    logic        relay_on;
    logic [7:0]  pwm_duty;
    mode_t       light_mode;
    logic        status_on;
    logic [6:0]  brightness_now;
  } result_t;

  // floor(x / 100), exact for x below 43690
  function automatic logic [8:0] div100(input logic [15:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(RECIP_100);
    return p[27:19];
  endfunction

endpackage

@@ rtl/core/lfds_if.sv @@
interface lfds_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       switch_on;
  logic [4:0] clock_hour;
  logic [5:0] clock_minute;

  modport source (output valid, action, switch_on, clock_hour, clock_minute, input ready);
  modport sink   (input valid, action, switch_on, clock_hour, clock_minute, output ready);
endinterface

interface lfds_result_if;
  logic       valid;
  logic       ready;
  logic       relay_on;
  logic [7:0] pwm_duty;
  logic [2:0] light_mode;
  logic       status_on;
  logic [6:0] brightness_now;

  modport source (output valid, relay_on, pwm_duty, light_mode, status_on, brightness_now,
                  input ready);
  modport sink   (input valid, relay_on, pwm_duty, light_mode, status_on, brightness_now,
                  output ready);
endinterface

interface lfds_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/led_light_fade_dim_schedule.sv @@
// A result beat is offered once its item has passed the state register, the stage-two register and the output buffer.
// Throughput: one item per cycle while output buffer credit is free; the state update is a single registered pass.
// A 4-entry output buffer with credit counting sets how far results may back up.
// Reset (rst, synchronous): state to off/zero, registers to their defaults,
// output buffer emptied; no clearing pass.
module led_light_fade_dim_schedule import lfds_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lfds_cfg_if.sink      cfg,
  lfds_item_if.sink     item,
  lfds_result_if.source result
);

  cfg_t        cfg_r;
  logic [7:0]  top;
  item_t       item_w;
  logic        accept;
  lstate_t     st;
  logic        s1_valid;

  logic        s2_valid;
  logic [14:0] s2_prod;
  mode_t       s2_mode;
  logic        s2_req;
  logic [6:0]  s2_level;

  logic [OBUF_AW:0] ob_count;
  logic [3:0]       used;
  result_t          wr_res;
  result_t          rd_res;
  logic [8:0]       cut;
  logic [6:0]       lim;
  logic [6:0]       span;
  logic [15:0]      scaled;
  logic [8:0]       top_next;

  assign cfg.ready = 1'b1;

  assign lim      = (cfg.data[6:0] > PERCENT_MAX) ? PERCENT_MAX : cfg.data[6:0];
  assign span     = PERCENT_MAX - lim;
  assign scaled   = {1'b0, span, 8'd0} - 16'(span);
  assign top_next = div100(scaled);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.target    <= 7'd100;
      cfg_r.interval  <= 16'd1;
      cfg_r.step      <= 7'd1;
      cfg_r.dim_ticks <= 17'd600;
      cfg_r.on_time   <= '0;
      cfg_r.off_time  <= '0;
      cfg_r.fading    <= 1'b0;
      cfg_r.sched     <= 1'b0;
      top             <= 8'd255;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_TARGET:   cfg_r.target   <= cfg.data[6:0];
        CFG_LIMIT:    top            <= top_next[7:0];
        CFG_INTERVAL: cfg_r.interval <= cfg.data;
        CFG_STEP:     cfg_r.step     <= cfg.data[6:0];
        CFG_DIM_DUR:  cfg_r.dim_ticks <= 17'({cfg.data[10:0], 6'd0}) -
                                         17'({cfg.data[10:0], 2'd0});
        CFG_ON_TIME:  cfg_r.on_time  <= cfg.data[10:0];
        CFG_OFF_TIME: cfg_r.off_time <= cfg.data[10:0];
        CFG_FLAGS:    {cfg_r.sched, cfg_r.fading} <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  assign used       = 4'(ob_count) + 4'(s1_valid) + 4'(s2_valid);
  assign item.ready = used < 4'(OBUF_DEPTH);
  assign accept     = item.valid && item.ready;

  assign item_w.action    = action_t'(item.action);
  assign item_w.switch_on = item.switch_on;
  assign item_w.hour      = item.clock_hour;
  assign item_w.minute    = item.clock_minute;

  lfds_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item_w),
    .cfg    (cfg_r),
    .st     (st),
    .done   (s1_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_prod  <= 15'(st.level) * 15'(top);
    s2_mode  <= st.mode;
    s2_req   <= st.req_on;
    s2_level <= st.level;
  end

  assign cut = div100({1'b0, s2_prod});

  assign wr_res.relay_on       = s2_mode != MODE_OFF;
  assign wr_res.pwm_duty       = (cut > 9'(top)) ? 8'd0 : top - cut[7:0];
  assign wr_res.light_mode     = s2_mode;
  assign wr_res.status_on      = s2_req;
  assign wr_res.brightness_now = s2_level;

  lfds_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (s2_valid),
    .wr_data  (wr_res),
    .rd_valid (result.valid),
    .rd_ready (result.ready),
    .rd_data  (rd_res),
    .count    (ob_count)
  );

  assign result.relay_on       = rd_res.relay_on;
  assign result.pwm_duty       = rd_res.pwm_duty;
  assign result.light_mode     = rd_res.light_mode;
  assign result.status_on      = rd_res.status_on;
  assign result.brightness_now = rd_res.brightness_now;

  a_credit: assert property (@(posedge clk) disable iff (rst)
    used <= 4'(OBUF_DEPTH))
    else $error("output buffer credit overrun");

  a_pipe: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid ##1 s2_valid)
    else $error("beat lost in pipeline");

  a_relay: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.relay_on == (result.light_mode != MODE_OFF))
    else $error("relay level disagrees with mode");

endmodule

@@ rtl/core/lfds_ctrl.sv @@
module lfds_ctrl import lfds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  item_t   item,
  input  cfg_t    cfg,
  output lstate_t st,
  output logic    done
);

  lstate_t st_next;

  function automatic lstate_t check_fade(input lstate_t s, input cfg_t c);
    lstate_t r;
    logic [7:0] v;
    r = s;
    v = 8'(s.level) + 8'(c.step);
    if (s.fade_sec >= c.interval) begin
      if (s.mode == MODE_FADEIN) begin
        if (v >= 8'(c.target)) begin
          r.level = c.target;
          r.mode  = MODE_ON;
        end else begin
          r.level = v[6:0];
        end
        r.fade_sec = '0;
      end else if (s.mode == MODE_FADEOUT) begin
        if (s.level <= c.step) begin
          r.level = '0;
          r.mode  = MODE_OFF;
        end else begin
          r.level = s.level - c.step;
        end
        r.fade_sec = '0;
      end
    end
    return r;
  endfunction

  function automatic lstate_t restore_dim(input lstate_t s, input cfg_t c);
    lstate_t r;
    r = s;
    r.mode  = s.saved_mode;
    r.level = s.saved_level;
    return check_fade(r, c);
  endfunction

  function automatic lstate_t check_all(input lstate_t s, input cfg_t c);
    lstate_t r;
    r = s;
    if (s.mode == MODE_DIMMED) begin
      if (s.dim_sec >= c.dim_ticks) r = restore_dim(s, c);
    end else begin
      r = check_fade(s, c);
    end
    return r;
  endfunction

  function automatic lstate_t set_light(input lstate_t s, input cfg_t c, input logic on);
    lstate_t r;
    r = s;
    if (on) begin
      if (c.fading && s.mode != MODE_FADEIN && s.mode != MODE_ON) begin
        r.mode  = MODE_FADEIN;
        r.level = '0;
      end else begin
        r.mode  = MODE_ON;
        r.level = c.target;
      end
    end else begin
      if (c.fading && s.mode != MODE_OFF && s.mode != MODE_FADEOUT) r.mode = MODE_FADEOUT;
      else r.mode = MODE_OFF;
    end
    r.req_on = on;
    return r;
  endfunction

  function automatic lstate_t check_sched(input lstate_t s, input cfg_t c, input item_t it);
    lstate_t r;
    logic [10:0] now;
    logic want;
    r = s;
    now = 11'({it.hour, 6'd0}) - 11'({it.hour, 2'd0}) + 11'(it.minute);
    if (c.on_time <= c.off_time) want = (c.on_time <= now) && (now < c.off_time);
    else want = (c.on_time <= now) || (now < c.off_time);
    if (c.sched) begin
      if (want && !s.req_on) r = set_light(s, c, 1'b1);
      else if (!want && s.req_on) r = set_light(s, c, 1'b0);
    end
    return r;
  endfunction

  function automatic lstate_t toggle_dim(input lstate_t s, input cfg_t c);
    lstate_t r;
    r = s;
    if (s.mode == MODE_DIMMED) begin
      r = restore_dim(s, c);
    end else begin
      r.saved_mode  = s.mode;
      r.saved_level = s.level;
      r.mode        = MODE_DIMMED;
      r.level       = 7'd1;
      r.dim_sec     = '0;
      r = check_all(r, c);
    end
    return r;
  endfunction

  always_comb begin
    lstate_t s;
    s = st;
    if (accept) begin
      case (item.action)
        ACT_SECOND: begin
          if (s.fade_sec < FADE_SEC_MAX) s.fade_sec = s.fade_sec + 16'd1;
          if (s.dim_sec < DIM_SEC_MAX) s.dim_sec = s.dim_sec + 17'd1;
          s = check_all(s, cfg);
        end
        ACT_MINUTE: s = check_sched(s, cfg, item);
        ACT_SWITCH: s = set_light(s, cfg, item.switch_on);
        ACT_DIM:    s = toggle_dim(s, cfg);
        default: ;
      endcase
    end
    st_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode        <= MODE_OFF;
      st.req_on      <= 1'b0;
      st.level       <= '0;
      st.saved_mode  <= MODE_OFF;
      st.saved_level <= '0;
      st.fade_sec    <= '0;
      st.dim_sec     <= '0;
      done           <= 1'b0;
    end else begin
      st   <= st_next;
      done <= accept;
    end
  end

  a_saved_not_dimmed: assert property (@(posedge clk) disable iff (rst)
    st.saved_mode != MODE_DIMMED)
    else $error("saved mode holds dimmed");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_ON && $past(accept) && $past(st.mode) != MODE_ON &&
     $past(st.mode) != MODE_DIMMED) |-> st.level == cfg.target)
    else $error("on entered without target level");

  a_dim_level: assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_DIMMED |-> st.level == 7'd1)
    else $error("dimmed mode with level other than one");

endmodule

@@ rtl/core/lfds_obuf.sv @@
module lfds_obuf import lfds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  result_t            wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output result_t            rd_data,
  output logic [OBUF_AW:0]   count
);

  result_t mem [OBUF_DEPTH];
  logic [OBUF_AW-1:0] wr_ptr;
  logic [OBUF_AW-1:0] rd_ptr;
  logic rd_en;

  assign rd_valid = count != '0;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (OBUF_AW+1)'(wr_en) - (OBUF_AW+1)'(rd_en);
    end
  end

endmodule

@@ dv/lfds_lamp_check.sv @@
module lfds_lamp_check import lfds_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  lfds_cfg_if    cfg,
  lfds_item_if   item,
  lfds_result_if result,
  output int     outstanding,
  output int     failures
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [6:0]  tgt_pct;
  logic [6:0]  limit_pct;
  logic [15:0] interval_s;
  logic [6:0]  step_pct;
  logic [10:0] dim_min;
  logic [10:0] sched_on;
  logic [10:0] sched_off;
  logic [1:0]  flags;

  mode_t       lamp;
  mode_t       saved_lamp;
  logic        req_on;
  logic [6:0]  pct;
  logic [6:0]  saved_pct;
  logic [15:0] fade_s;
  logic [16:0] dim_s;

  result_t     lamp_due_q[$];

  function automatic void fade_tick();
    int v;
    if (lamp == MODE_FADEIN && fade_s >= interval_s) begin
      v = int'(pct) + int'(step_pct);
      if (v >= int'(tgt_pct)) begin
        v = int'(tgt_pct);
        lamp = MODE_ON;
      end
      pct = 7'(v);
      fade_s = '0;
    end else if (lamp == MODE_FADEOUT && fade_s >= interval_s) begin
      if (pct <= step_pct) begin
        pct = '0;
        lamp = MODE_OFF;
      end else begin
        pct = pct - step_pct;
      end
      fade_s = '0;
    end
  endfunction

  function automatic void undim();
    lamp = saved_lamp;
    pct = saved_pct;
    fade_tick();
  endfunction

  function automatic void settle();
    if (lamp == MODE_DIMMED) begin
      if (int'(dim_s) >= int'(dim_min) * 60) undim();
    end else begin
      fade_tick();
    end
  endfunction

  function automatic void switch_lamp(logic on);
    if (on) begin
      if (flags[0] && lamp != MODE_FADEIN && lamp != MODE_ON) begin
        lamp = MODE_FADEIN;
        pct = '0;
      end else begin
        lamp = MODE_ON;
        pct = tgt_pct;
      end
    end else if (flags[0] && lamp != MODE_OFF && lamp != MODE_FADEOUT) begin
      lamp = MODE_FADEOUT;
    end else begin
      lamp = MODE_OFF;
    end
    req_on = on;
  endfunction

  function automatic result_t next_lamp(item_t it);
    int      now_min;
    int      lim;
    int      full;
    int      cut;
    logic    want;
    result_t r;
    case (it.action)
      ACT_SECOND: begin
        if (fade_s != FADE_SEC_MAX) fade_s = fade_s + 1'b1;
        if (dim_s != DIM_SEC_MAX) dim_s = dim_s + 1'b1;
        settle();
      end
      ACT_MINUTE: begin
        if (flags[1]) begin
          now_min = int'(it.hour) * 60 + int'(it.minute);
          if (sched_on <= sched_off)
            want = int'(sched_on) <= now_min && now_min < int'(sched_off);
          else
            want = int'(sched_on) <= now_min || now_min < int'(sched_off);
          if (want != req_on) switch_lamp(want);
        end
      end
      ACT_SWITCH: switch_lamp(it.switch_on);
      default: begin
        if (lamp == MODE_DIMMED) begin
          undim();
        end else begin
          saved_lamp = lamp;
          saved_pct = pct;
          lamp = MODE_DIMMED;
          pct = 7'd1;
          dim_s = '0;
          settle();
        end
      end
    endcase
    lim = limit_pct > PERCENT_MAX ? 100 : int'(limit_pct);
    full = 255 * (100 - lim) / 100;
    cut = int'(pct) * full / 100;
    r.relay_on = lamp != MODE_OFF;
    r.pwm_duty = cut > full ? 8'd0 : 8'(full - cut);
    r.light_mode = lamp;
    r.status_on = req_on;
    r.brightness_now = pct;
    return r;
  endfunction

  function automatic void check_field(string fld, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fld, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : watch
    item_t   beat_in;
    result_t due;
    if (rst) begin
      tgt_pct = 7'd100;
      limit_pct = '0;
      interval_s = 16'd1;
      step_pct = 7'd1;
      dim_min = 11'd10;
      sched_on = '0;
      sched_off = '0;
      flags = '0;
      lamp = MODE_OFF;
      saved_lamp = MODE_OFF;
      req_on = 1'b0;
      pct = '0;
      saved_pct = '0;
      fade_s = '0;
      dim_s = '0;
      lamp_due_q.delete();
      failures = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (lamp_due_q.size() == 0) begin
          $error("result beat with no expected result");
          failures++;
        end else begin
          due = lamp_due_q.pop_front();
          check_field("relay_on", 8'(due.relay_on), 8'(result.relay_on));
          check_field("pwm_duty", due.pwm_duty, result.pwm_duty);
          check_field("light_mode", 8'(due.light_mode), 8'(result.light_mode));
          check_field("status_on", 8'(due.status_on), 8'(result.status_on));
          check_field("brightness_now", 8'(due.brightness_now), 8'(result.brightness_now));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_TARGET:   tgt_pct = cfg.data[6:0];
          CFG_LIMIT:    limit_pct = cfg.data[6:0];
          CFG_INTERVAL: interval_s = cfg.data;
          CFG_STEP:     step_pct = cfg.data[6:0];
          CFG_DIM_DUR:  dim_min = cfg.data[10:0];
          CFG_ON_TIME:  sched_on = cfg.data[10:0];
          CFG_OFF_TIME: sched_off = cfg.data[10:0];
          default:      flags = cfg.data[1:0];
        endcase
      end
      if (item.valid && item.ready) begin
        beat_in.action = action_t'(item.action);
        beat_in.switch_on = item.switch_on;
        beat_in.hour = item.clock_hour;
        beat_in.minute = item.clock_minute;
        lamp_due_q.push_back(next_lamp(beat_in));
      end
    end
    outstanding = lamp_due_q.size();
  end

endmodule

@@ dv/tb_led_light_fade_dim_schedule.sv @@
module tb_led_light_fade_dim_schedule;
  timeunit 1ns;
  timeprecision 1ps;
  import lfds_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 17;
  localparam int PHASE_LEN  = 60;

  logic clk = 1'b0;
  logic rst;
  int   outstanding;
  int   failures;
  bit   feed_calm;
  bit   drain_calm;
  int   on_now;
  int   off_now;

  lfds_cfg_if    cfg();
  lfds_item_if   item();
  lfds_result_if result();

  led_light_fade_dim_schedule dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  lfds_lamp_check u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (item),
    .result      (result),
    .outstanding (outstanding),
    .failures    (failures)
  );

  always #6 clk = ~clk;

  function automatic int gap(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send(action_t act, logic sw, logic [4:0] hr, logic [5:0] mn);
    int k;
    k = gap(feed_calm);
    if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
    if (k > 0) begin
      item.valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.action <= act;
    item.switch_on <= sw;
    item.clock_hour <= hr;
    item.clock_minute <= mn;
    do @(posedge clk); while (!item.ready);
  endtask

  // hold off until every result is back, then let the pipeline settle
  task automatic drain();
    item.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val, int w);
    logic [15:0] d;
    d = 16'(val);
    if (w < 16 && $urandom_range(0, 3) == 0) d = d | (16'($urandom) << w);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic apply_config(int tgt, int lim, int intv, int stp, int dur, int ton,
                              int toff, int flg);
    write_reg(CFG_TARGET, tgt, 7);
    write_reg(CFG_LIMIT, lim, 7);
    write_reg(CFG_INTERVAL, intv, 16);
    write_reg(CFG_STEP, stp, 7);
    write_reg(CFG_DIM_DUR, dur, 11);
    write_reg(CFG_ON_TIME, ton, 11);
    write_reg(CFG_OFF_TIME, toff, 11);
    write_reg(CFG_FLAGS, flg, 2);
    cfg.valid <= 1'b0;
    on_now = ton;
    off_now = toff;
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 100;
      2: return 127;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  task automatic random_config();
    int tgt;
    int lim;
    int intv;
    int stp;
    int dur;
    int ton;
    int toff;
    tgt = pick_pct();
    lim = pick_pct();
    intv = $urandom_range(0, 9) == 0 ? 65535 : $urandom_range(0, 4);
    case ($urandom_range(0, 5))
      0: stp = 0;
      1: stp = 100;
      default: stp = $urandom_range(1, 30);
    endcase
    dur = $urandom_range(0, 9) == 0 ? 1440 : $urandom_range(0, 2);
    ton = $urandom_range(0, 1439);
    toff = $urandom_range(0, 7) == 0 ? ton : $urandom_range(0, 1439);
    apply_config(tgt, lim, intv, stp, dur, ton, toff, $urandom_range(0, 3));
  endtask

  task automatic send_minute();
    int t;
    case ($urandom_range(0, 3))
      0: send(ACT_MINUTE, 1'($urandom), 5'($urandom_range(0, 31)),
              6'($urandom_range(0, 63)));
      1, 2: begin
        t = ($urandom_range(0, 1) ? on_now : off_now) + 1439 + $urandom_range(0, 2);
        t = t % 1440;
        send(ACT_MINUTE, 1'($urandom), 5'(t / 60), 6'(t % 60));
      end
      default: send(ACT_MINUTE, 1'($urandom), 5'($urandom_range(0, 23)),
                    6'($urandom_range(0, 59)));
    endcase
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r == 0) begin
        repeat ($urandom_range(60, 70)) send(ACT_SECOND, 1'($urandom), 5'($urandom),
                                             6'($urandom));
      end else if (r < 62) begin
        send(ACT_SECOND, 1'($urandom), 5'($urandom), 6'($urandom));
      end else if (r < 74) begin
        send_minute();
      end else if (r < 87) begin
        send(ACT_SWITCH, 1'($urandom), 5'($urandom), 6'($urandom));
      end else begin
        send(ACT_DIM, 1'($urandom), 5'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin : drain_side
    int k;
    result.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      k = gap(drain_calm);
      if ($urandom_range(0, 39) == 0) drain_calm = !drain_calm;
      if (k > 0) begin
        result.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!(result.valid && result.ready));
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (item.valid && item.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready))
        idle = 0;
      else
        idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item.valid = 1'b0;
    item.action = ACT_SECOND;
    item.switch_on = 1'b0;
    item.clock_hour = '0;
    item.clock_minute = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_TARGET;
    cfg.data = '0;
    on_now = 0;
    off_now = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send(ACT_SECOND, 1'b0, 5'd0, 6'd0);
    send(ACT_MINUTE, 1'b1, 5'd31, 6'd63);
    send(ACT_SWITCH, 1'b1, 5'd0, 6'd0);
    send(ACT_DIM, 1'b0, 5'd0, 6'd0);
    send(ACT_SECOND, 1'b0, 5'd0, 6'd0);
    send(ACT_DIM, 1'b0, 5'd0, 6'd0);
    send(ACT_SWITCH, 1'b0, 5'd31, 6'd63);
    drain();

    // schedule across midnight, no dimming time, oversized target and limit
    apply_config(127, 127, 0, 100, 0, 1439, 0, 3);
    send(ACT_MINUTE, 1'b0, 5'd23, 6'd59);
    send(ACT_SECOND, 1'b0, 5'd0, 6'd0);
    send(ACT_SECOND, 1'b0, 5'd0, 6'd0);
    send(ACT_DIM, 1'b0, 5'd0, 6'd0);
    send(ACT_MINUTE, 1'b0, 5'd0, 6'd0);
    send(ACT_SECOND, 1'b0, 5'd0, 6'd0);
    send(ACT_SECOND, 1'b0, 5'd0, 6'd0);
    send(ACT_SWITCH, 1'b1, 5'd0, 6'd0);
    send(ACT_SWITCH, 1'b1, 5'd0, 6'd0);
    drain();

    // equal schedule times, full-scale duty with brightness above 100
    apply_config(127, 0, 1, 1, 1440, 600, 600, 3);
    send(ACT_SWITCH, 1'b1, 5'd0, 6'd0);
    send(ACT_SWITCH, 1'b0, 5'd0, 6'd0);
    send(ACT_SWITCH, 1'b0, 5'd0, 6'd0);
    send(ACT_MINUTE, 1'b0, 5'd10, 6'd0);
    send(ACT_DIM, 1'b0, 5'd0, 6'd0);
    send(ACT_SWITCH, 1'b1, 5'd0, 6'd0);
    send(ACT_SECOND, 1'b0, 5'd0, 6'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      random_config();
      random_phase(PHASE_LEN);
      drain();
    end

    if (failures == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
